// File: rtl/core/hqb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hqb_pkg
// Shared types and constants of the histogram quantile break generator.
// ----------------------------------------------------------------------------
package hqb_pkg;

    // Widths fixed by the item and register formats.
    localparam int CNT_IN_W  = 24;
    localparam int IDX_IN_W  = 6;
    localparam int VALUE_W   = 32;
    localparam int TOTAL_W   = 30;
    localparam int NB_CFG_W  = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BUCKETS = 3'd0,
        CFG_NUM_CLASSES = 3'd1,
        CFG_MIN_VALUE   = 3'd2,
        CFG_MAX_VALUE   = 3'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD     = 1'b0,
        ACT_GENERATE = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PC_GO,
        ST_PC_WAIT,
        ST_SP_GO,
        ST_SP_WAIT,
        ST_WALK_RD,
        ST_WALK_EV
    } t_state;

    localparam logic [NB_CFG_W-1:0] RST_NUM_BUCKETS = 7'd64;
    localparam logic [NB_CFG_W-1:0] RST_NUM_CLASSES = 7'd4;
    localparam logic [VALUE_W-1:0]  RST_MIN_VALUE   = 32'd0;
    localparam logic [VALUE_W-1:0]  RST_MAX_VALUE   = 32'd65536;

endpackage
`default_nettype wire

// File: rtl/core/hqb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hqb_in_if
// Input channel: one load or generate command per transfer.
// ----------------------------------------------------------------------------
interface hqb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  bucket_index;
    logic [23:0] bucket_count;

    modport source (output valid, action, bucket_index, bucket_count, input ready);
    modport sink   (input valid, action, bucket_index, bucket_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/hqb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hqb_out_if
// Output channel: one class break per transfer.
// ----------------------------------------------------------------------------
interface hqb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] low_value;
    logic signed [31:0] high_value;
    logic        [29:0] total_count;
    logic               last_break;

    modport source (output valid, low_value, high_value, total_count, last_break,
                    input ready);
    modport sink   (input valid, low_value, high_value, total_count, last_break,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/core/hqb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hqb_store
// Bucket count memory with one write port and one registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module hqb_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;
endmodule
`default_nettype wire

// File: rtl/core/hqb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hqb_div
// Restoring unsigned divider, one quotient bit per cycle.
// The result holds from the done pulse until the next start.
// ----------------------------------------------------------------------------
module hqb_div #(
    parameter int DW = 39,
    parameter int VW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic      [DW-1:0] o_quot,
    output logic      [VW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quot[DW-1]};
        q_bit   = (rem_sh >= {1'b0, r_div});
        rem_sub = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-2:0], q_bit};
            r_rem  <= rem_sub[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// File: rtl/core/histogram_quantile_breaks.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_quantile_breaks
// Quantile class breaks over a histogram of bucket counts.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one command per transfer. A load (action 0)
// writes one bucket count; a load whose index is at or beyond the effective
// bucket count is dropped. A generate (action 1) yields one output transfer
// per class break, the final one flagged by last_break. Configuration is
// written through the plain write port; the user must write it only while the
// block idles, as the block itself does not enforce this.
// A generate sums the counts from the bucket memory, makes two passes of the
// shared bit-serial divider (class size, then the edge step), and walks the
// memory again, one read and one evaluation per bucket. Edges are stepped
// incrementally, so no division per edge. A new command is accepted once the
// walk ends, even while the last break still waits in the output register.
// Reset: synchronous and active low. It restores the register defaults and
// marks every bucket as zero through per-entry valid bits, with no clearing
// pass. When the receiver stalls, the walk holds at the next break until the
// output register is free; nothing is lost.
// ----------------------------------------------------------------------------
module histogram_quantile_breaks #(
    parameter int MAX_BUCKETS = 64,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hqb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hqb_pkg::VALUE_W-1:0]    i_cfg_data,
    hqb_in_if.sink                              i_in_ch,
    hqb_out_if.source                           o_out_ch
);
    import hqb_pkg::*;

    localparam int IW     = $clog2(MAX_BUCKETS);
    localparam int NB_W   = $clog2(MAX_BUCKETS + 1);
    localparam int TOT_W  = COUNT_BITS + IW;
    localparam int CEIL_W = TOT_W + 1;
    localparam int TGT_W  = TOT_W + 7;
    localparam int DIV_W  = (CEIL_W > VALUE_W) ? CEIL_W : VALUE_W;

    // Configuration registers.
    logic [NB_CFG_W-1:0] r_num_buckets;
    logic [NB_CFG_W-1:0] r_num_classes;
    logic [VALUE_W-1:0]  r_min;
    logic [VALUE_W-1:0]  r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= RST_NUM_BUCKETS;
            r_num_classes <= RST_NUM_CLASSES;
            r_min         <= RST_MIN_VALUE;
            r_max         <= RST_MAX_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_BUCKETS: r_num_buckets <= i_cfg_data[NB_CFG_W-1:0];
                CFG_NUM_CLASSES: r_num_classes <= i_cfg_data[NB_CFG_W-1:0];
                CFG_MIN_VALUE:   r_min         <= i_cfg_data;
                CFG_MAX_VALUE:   r_max         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective bucket and class counts: zero reads as one, and the bucket
    // count is capped at the memory depth.
    logic [NB_W-1:0]     n_eff;
    logic [NB_CFG_W-1:0] classes_eff;

    always_comb begin
        if (r_num_buckets == '0) begin
            n_eff = NB_W'(1);
        end else if (r_num_buckets > NB_CFG_W'(MAX_BUCKETS)) begin
            n_eff = NB_W'(MAX_BUCKETS);
        end else begin
            n_eff = NB_W'(r_num_buckets);
        end
        classes_eff = (r_num_classes == '0) ? NB_CFG_W'(1) : r_num_classes;
    end

    // Range span in 33 bits; its magnitude always fits in 32.
    logic [VALUE_W:0]   span;
    logic [VALUE_W:0]   span_inv;
    logic               span_neg;
    logic [VALUE_W-1:0] span_mag;

    always_comb begin
        span     = {r_max[VALUE_W-1], r_max} - {r_min[VALUE_W-1], r_min};
        span_inv = ~span + 1'b1;
        span_neg = span[VALUE_W];
        span_mag = span_neg ? span_inv[VALUE_W-1:0] : span[VALUE_W-1:0];
    end

    // Sequencer registers.
    t_state             r_state, n_state;
    logic [NB_W-1:0]    r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [TOT_W-1:0]   r_sum, n_sum;
    logic [TOT_W-1:0]   r_acc, n_acc;
    logic [TGT_W-1:0]   r_target, n_target;
    logic [TGT_W-1:0]   r_per_class, n_per_class;
    logic [VALUE_W-1:0] r_step_q, n_step_q;
    logic [NB_CFG_W-1:0] r_step_r, n_step_r;
    logic [VALUE_W-1:0] r_q, n_q;
    logic [NB_CFG_W-1:0] r_rem, n_rem;
    logic [VALUE_W-1:0] r_low, n_low;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_low, n_out_low;
    logic [VALUE_W-1:0] r_out_high, n_out_high;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_last, n_out_last;

    // Memory and divider hookup.
    logic                  st_wr_en;
    logic                  st_rd_en;
    logic [IW-1:0]         st_rd_addr;
    logic [COUNT_BITS-1:0] st_rd_data;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [NB_CFG_W-1:0]   div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quot;
    logic [NB_CFG_W-1:0]   div_rem;

    logic                  in_xfer;
    logic [CEIL_W-1:0]     ceil_num;
    logic [TOTAL_W-1:0]    total_sat;

    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign in_xfer       = i_in_ch.valid && i_in_ch.ready;
    assign st_wr_en      = in_xfer && (i_in_ch.action == ACT_LOAD)
                           && (NB_CFG_W'(i_in_ch.bucket_index) < NB_CFG_W'(n_eff));

    assign ceil_num  = CEIL_W'(r_sum) + CEIL_W'(classes_eff) - CEIL_W'(1);
    assign total_sat = ((TOT_W > TOTAL_W) && ((r_sum >> TOTAL_W) != '0))
                       ? '1 : TOTAL_W'(r_sum);

    assign div_dividend = (r_state == ST_SP_GO) ? DIV_W'(span_mag) : DIV_W'(ceil_num);
    assign div_divisor  = (r_state == ST_SP_GO) ? NB_CFG_W'(n_eff) : classes_eff;

    hqb_store #(
        .DEPTH (MAX_BUCKETS),
        .WIDTH (COUNT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (i_in_ch.bucket_index[IW-1:0]),
        .i_wr_data (COUNT_BITS'(i_in_ch.bucket_count)),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    hqb_div #(
        .DW (DIV_W),
        .VW (NB_CFG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Walk evaluation: running sum, break test and the next bucket edge.
    // The edge index i+1 is tracked as q*n + rem = |span|*(i+1), advanced by
    // the precomputed step |span| = step_q*n + step_r.
    logic [TOT_W-1:0]    acc_next;
    logic                is_last;
    logic                is_break;
    logic                out_free;
    logic [NB_CFG_W:0]   rem_sum;
    logic                rem_wrap;
    logic [VALUE_W-1:0]  q_next;
    logic [NB_CFG_W-1:0] rem_next;
    logic [VALUE_W-1:0]  high_edge;

    always_comb begin
        acc_next  = r_acc + TOT_W'(st_rd_data);
        is_last   = (r_ptr == n_eff - NB_W'(1));
        is_break  = (TGT_W'(acc_next) >= r_target) || is_last;
        out_free  = !r_out_valid || o_out_ch.ready;
        rem_sum   = {1'b0, r_rem} + {1'b0, r_step_r};
        rem_wrap  = (rem_sum >= (NB_CFG_W + 1)'(n_eff));
        q_next    = r_q + r_step_q + VALUE_W'(rem_wrap);
        rem_next  = rem_wrap ? NB_CFG_W'(rem_sum - (NB_CFG_W + 1)'(n_eff))
                             : NB_CFG_W'(rem_sum);
        high_edge = r_min + (span_neg ? (~q_next + 1'b1) : q_next);
    end

    // Next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_target    = r_target;
        n_per_class = r_per_class;
        n_step_q    = r_step_q;
        n_step_r    = r_step_r;
        n_q         = r_q;
        n_rem       = r_rem;
        n_low       = r_low;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_total = r_out_total;
        n_out_last  = r_out_last;
        st_rd_en    = 1'b0;
        st_rd_addr  = r_ptr[IW-1:0];
        div_start   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_in_ch.action == ACT_GENERATE)) begin
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_sum   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_pend) begin
                    n_sum = r_sum + TOT_W'(st_rd_data);
                end
                if (r_ptr < n_eff) begin
                    st_rd_en = 1'b1;
                    n_ptr    = r_ptr + 1'b1;
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ST_PC_GO;
                    end
                end
            end
            ST_PC_GO: begin
                div_start = 1'b1;
                n_state   = ST_PC_WAIT;
            end
            ST_PC_WAIT: begin
                if (div_done) begin
                    n_per_class = TGT_W'(div_quot);
                    n_target    = TGT_W'(div_quot);
                    n_state     = ST_SP_GO;
                end
            end
            ST_SP_GO: begin
                div_start = 1'b1;
                n_state   = ST_SP_WAIT;
            end
            ST_SP_WAIT: begin
                if (div_done) begin
                    n_step_q = div_quot[VALUE_W-1:0];
                    n_step_r = div_rem;
                    n_q      = '0;
                    n_rem    = '0;
                    n_acc    = '0;
                    n_low    = r_min;
                    n_ptr    = '0;
                    n_state  = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                st_rd_en = 1'b1;
                n_state  = ST_WALK_EV;
            end
            ST_WALK_EV: begin
                if (!is_break || out_free) begin
                    n_acc = acc_next;
                    n_q   = q_next;
                    n_rem = rem_next;
                    if (is_break) begin
                        n_out_valid = 1'b1;
                        n_out_low   = r_low;
                        n_out_high  = is_last ? r_max : high_edge;
                        n_out_total = total_sat;
                        n_out_last  = is_last;
                        n_low       = high_edge;
                        n_target    = r_target + r_per_class;
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        n_state = ST_WALK_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_sum       <= n_sum;
        r_acc       <= n_acc;
        r_target    <= n_target;
        r_per_class <= n_per_class;
        r_step_q    <= n_step_q;
        r_step_r    <= n_step_r;
        r_q         <= n_q;
        r_rem       <= n_rem;
        r_low       <= n_low;
        r_out_low   <= n_out_low;
        r_out_high  <= n_out_high;
        r_out_total <= n_out_total;
        r_out_last  <= n_out_last;
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.low_value   = r_out_low;
    assign o_out_ch.high_value  = r_out_high;
    assign o_out_ch.total_count = r_out_total;
    assign o_out_ch.last_break  = r_out_last;
endmodule
`default_nettype wire

// File: sim/tb_histogram_quantile_breaks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_quantile_breaks
// Self-checking bench for the histogram quantile break generator. A queue of
// load and generate commands feeds a clocked driver on the input channel. The
// bench keeps its own copy of the bucket store and registers, and works out
// every class break that an accepted generate must yield. A clocked monitor
// checks each output transfer, field by field, against the oldest break
// still outstanding. Directed commands cover the corner cases first. Four
// randomised phases then follow, each with its own register setting and its
// own pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_histogram_quantile_breaks;
    import hqb_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_BUCKETS    = 64;
    localparam int COUNT_BITS     = 24;
    // Long enough for a generate over the full 64-bucket store, so this settles
    // any work still in flight.
    localparam int GEN_LATENCY    = 300;
    localparam int LONG_HOLD      = 600;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam longint TOTAL_SAT  = (64'd1 << TOTAL_W) - 1;

    localparam logic [VALUE_W-1:0] Q_MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] Q_MOST_POS = 32'h7FFF_FFFF;
    // Register indexes past the last real register; a write there is a no-op.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        t_action             action;
        logic [IDX_IN_W-1:0] bucket_index;
        logic [CNT_IN_W-1:0] bucket_count;
    } t_hist_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] low_value;
        logic [VALUE_W-1:0] high_value;
        logic [TOTAL_W-1:0] total_count;
        logic               last_break;
    } t_class_break;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VALUE_W-1:0]   i_cfg_data;

    hqb_in_if  in_ch ();
    hqb_out_if out_ch ();

    histogram_quantile_breaks #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .COUNT_BITS  (COUNT_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Commands waiting for the driver, and breaks waiting for the monitor.
    t_hist_cmd    pending_cmds[$];
    t_class_break expected_breaks[$];

    // The bench's own copy of the bucket store and the four registers.
    logic [CNT_IN_W-1:0]   count_mirror [MAX_BUCKETS];
    logic [NB_CFG_W-1:0]   nb_reg;
    logic [NB_CFG_W-1:0]   nc_reg;
    logic signed [VALUE_W-1:0] min_reg;
    logic signed [VALUE_W-1:0] max_reg;

    int  mismatch_cnt    = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    int  hold_req        = 0;
    int  hold_ack        = 0;
    int  hold_left       = 0;
    logic in_taken       = 1'b0;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A bucket setting of zero acts as one bucket, and anything past the
    // store depth is clamped to the full store.
    function automatic int unsigned active_buckets();
        if (nb_reg == 0) begin
            return 1;
        end
        return (nb_reg > MAX_BUCKETS) ? MAX_BUCKETS : nb_reg;
    endfunction

    // Edge of bucket idx out of n over [min, max]. The product is exact in
    // 64 bits and the quotient truncates toward zero, so an inverted range
    // simply gives descending edges.
    function automatic logic [VALUE_W-1:0] bucket_bound(int unsigned idx, int unsigned n);
        longint span;
        longint pos;
        span = longint'(max_reg) - longint'(min_reg);
        pos  = longint'(min_reg) + (span * longint'(idx)) / longint'(n);
        return pos[VALUE_W-1:0];
    endfunction

    // Applies one accepted command to the mirrored store and queues the
    // class breaks that it must produce.
    function automatic void predict_command(t_action act, logic [IDX_IN_W-1:0] idx,
                                            logic [CNT_IN_W-1:0] cnt);
        int unsigned  n;
        int unsigned  classes;
        int unsigned  class_start;
        longint       total;
        longint       per_class;
        longint       target;
        longint       running;
        bit           is_last;
        t_class_break brk;
        n = active_buckets();
        if (act == ACT_LOAD) begin
            // Loads past the buckets in use are dropped silently.
            if (idx < n) begin
                count_mirror[idx] = cnt;
            end
            return;
        end
        classes = (nc_reg == 0) ? 1 : nc_reg;
        total   = 0;
        for (int unsigned i = 0; i < n; i++) begin
            total += count_mirror[i];
        end
        // A zero total leaves per_class at zero, so every bucket closes a class.
        per_class   = (total + classes - 1) / classes;
        target      = per_class;
        running     = 0;
        class_start = 0;
        for (int unsigned i = 0; i < n; i++) begin
            is_last  = (i == n - 1);
            running += count_mirror[i];
            if (running >= target || is_last) begin
                brk.low_value = bucket_bound(class_start, n);
                if (is_last) begin
                    brk.high_value = max_reg;
                end else begin
                    brk.high_value = bucket_bound(i + 1, n);
                    target        += per_class;
                    class_start    = i + 1;
                end
                brk.total_count = (total > TOTAL_SAT) ? TOTAL_SAT[TOTAL_W-1:0]
                                                      : total[TOTAL_W-1:0];
                brk.last_break  = is_last;
                expected_breaks.push_back(brk);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input channel: driver and acceptance monitor
    // ------------------------------------------------------------------------

    // The driver works on the falling edge. A command stays on the channel
    // until a transfer takes it; only then may the sender pause or move on.
    always @(negedge i_clk) begin : cmd_driver
        t_hist_cmd nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                nxt = pending_cmds.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.action       <= nxt.action;
                in_ch.bucket_index <= nxt.bucket_index;
                in_ch.bucket_count <= nxt.bucket_count;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Each input transfer is seen at the rising edge and predicted at once,
    // so the breaks queue up in the order the block must emit them.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_command(t_action'(in_ch.action), in_ch.bucket_index,
                            in_ch.bucket_count);
        end
    end

    // ------------------------------------------------------------------------
    // Output channel: receiver and checker
    // ------------------------------------------------------------------------

    // The receiver stalls at random. On request it holds ready low for a long
    // stretch, so that the output register fills up and the input backs up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            out_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
            hold_ack     <= hold_req;
        end else begin
            out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic compare_field(string field, logic [VALUE_W-1:0] want,
                                 logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : break_checker
        t_class_break want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_breaks.size() == 0) begin
                $display("%0t: break expected none actual low %h high %h total %0d last %0b",
                         $time, out_ch.low_value, out_ch.high_value,
                         out_ch.total_count, out_ch.last_break);
                mismatch_cnt++;
            end else begin
                want = expected_breaks.pop_front();
                compare_field("low_value",   want.low_value,   out_ch.low_value);
                compare_field("high_value",  want.high_value,  out_ch.high_value);
                compare_field("total_count", want.total_count, out_ch.total_count);
                compare_field("last_break",  want.last_break,  out_ch.last_break);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic void add_load(logic [IDX_IN_W-1:0] idx, logic [CNT_IN_W-1:0] cnt);
        t_hist_cmd c;
        c.action       = ACT_LOAD;
        c.bucket_index = idx;
        c.bucket_count = cnt;
        pending_cmds.push_back(c);
    endfunction

    // Index and count mean nothing on a generate, so they carry random junk.
    function automatic void add_generate();
        t_hist_cmd c;
        c.action       = ACT_GENERATE;
        c.bucket_index = $urandom;
        c.bucket_count = $urandom;
        pending_cmds.push_back(c);
    endfunction

    // Blocks until every queued command has gone across and every predicted
    // break has come back, then lets the block settle. The check runs at the
    // rising edge, where the driver's falling-edge updates have settled.
    task automatic wait_drained(int settle);
        do begin
            @(posedge i_clk);
        end while (pending_cmds.size() != 0 || in_ch.valid || expected_breaks.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    // Writes all four registers back to back, then one spare index that must
    // change nothing. The narrow registers get junk in their upper data bits.
    task automatic program_regs(logic [NB_CFG_W-1:0] nb, logic [NB_CFG_W-1:0] nc,
                                logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi);
        logic [VALUE_W-1:0] word;
        @(negedge i_clk);
        word = $urandom;
        word[NB_CFG_W-1:0] = nb;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NUM_BUCKETS;
        i_cfg_data  <= word;
        nb_reg       = nb;
        @(negedge i_clk);
        word = $urandom;
        word[NB_CFG_W-1:0] = nc;
        i_cfg_index <= CFG_NUM_CLASSES;
        i_cfg_data  <= word;
        nc_reg       = nc;
        @(negedge i_clk);
        i_cfg_index <= CFG_MIN_VALUE;
        i_cfg_data  <= lo;
        min_reg      = lo;
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_VALUE;
        i_cfg_data  <= hi;
        max_reg      = hi;
        @(negedge i_clk);
        i_cfg_index <= $urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO);
        i_cfg_data  <= $urandom;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One randomised phase: a fresh register setting, then bursts of loads
    // each closed by a generate, so that most generates see fresh counts. The
    // sender stops halfway until all breaks are back.
    task automatic run_random_phase(int idle_pct, int stall_pct, int n_items, bit with_hold);
        logic [NB_CFG_W-1:0] nb;
        logic [NB_CFG_W-1:0] nc;
        logic [VALUE_W-1:0]  lo;
        logic [VALUE_W-1:0]  hi;
        logic [CNT_IN_W-1:0] cnt;
        logic [IDX_IN_W-1:0] idx;
        int unsigned         n;
        int                  made;
        bit                  paused;
        wait_drained(GEN_LATENCY);
        case ($urandom_range(3, 0))
            0:       nb = $urandom_range(8, 1);
            1:       nb = $urandom_range(MAX_BUCKETS, 1);
            2:       nb = $urandom_range(127, 0);
            default: nb = ($urandom_range(1, 0) != 0) ? 7'd127 : 7'd0;
        endcase
        case ($urandom_range(3, 0))
            0, 1:    nc = $urandom_range(16, 1);
            2:       nc = $urandom_range(127, 0);
            default: nc = ($urandom_range(1, 0) != 0) ? 7'd64 : 7'd0;
        endcase
        case ($urandom_range(3, 0))
            0: begin
                lo = $urandom;
                hi = $urandom;
            end
            1: begin
                lo = Q_MOST_NEG;
                hi = Q_MOST_POS;
            end
            2: begin
                lo = Q_MOST_POS;
                hi = Q_MOST_NEG;
            end
            default: begin
                lo = $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
                hi = lo + $urandom_range(32'h0100_0000, 0);
            end
        endcase
        program_regs(nb, nc, lo, hi);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        n      = active_buckets();
        made   = 0;
        paused = 1'b0;
        if (with_hold) begin
            // Back-to-back generates against a receiver that has gone quiet.
            add_generate();
            add_generate();
            add_generate();
            made    += 3;
            hold_req = hold_req + 1;
        end
        while (made < n_items) begin
            if (!paused && made >= n_items / 2) begin
                wait_drained(0);
                paused = 1'b1;
            end
            repeat ($urandom_range(6, 0)) begin
                if ($urandom_range(9, 0) != 0) begin
                    idx = $urandom_range(n - 1, 0);
                end else begin
                    idx = $urandom_range(MAX_BUCKETS - 1, 0);
                end
                case ($urandom_range(9, 0))
                    0:       cnt = '0;
                    1:       cnt = '1;
                    2, 3:    cnt = $urandom_range(15, 0);
                    default: cnt = $urandom;
                endcase
                add_load(idx, cnt);
                if (idx < n) begin
                    made++;
                end
            end
            add_generate();
            made++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_NUM_BUCKETS;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_LOAD;
        in_ch.bucket_index = '0;
        in_ch.bucket_count = '0;
        out_ch.ready       = 1'b0;

        // The block comes out of reset with the register defaults and an
        // empty store; the mirror starts from the same place.
        nb_reg  = RST_NUM_BUCKETS;
        nc_reg  = RST_NUM_CLASSES;
        min_reg = RST_MIN_VALUE;
        max_reg = RST_MAX_VALUE;
        foreach (count_mirror[i]) begin
            count_mirror[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: the total is zero, so all 64 buckets close a class.
        add_generate();
        // Largest counts at both ends of the store, a single count between.
        add_load(6'd0, '1);
        add_load(6'd63, '1);
        add_load(6'd21, 24'd1);
        add_generate();
        wait_drained(GEN_LATENCY);

        // Zero buckets and zero classes both act as one, over the widest range.
        // The load to bucket 1 is out of range and must not land.
        program_regs(7'd0, 7'd0, Q_MOST_NEG, Q_MOST_POS);
        add_load(6'd1, 24'd5);
        add_load(6'd0, 24'd7);
        add_generate();
        wait_drained(GEN_LATENCY);

        // Oversized settings clamp to the full store; the range is inverted,
        // so the edges descend. Bucket 1 is visible again, still unwritten.
        program_regs(7'd127, 7'd127, Q_MOST_POS, Q_MOST_NEG);
        add_generate();
        add_load(6'd63, 24'd0);
        add_generate();
        wait_drained(GEN_LATENCY);

        // Two buckets, more classes than counts.
        program_regs(7'd2, 7'd64, 32'hFFFF_0000, 32'h0003_0000);
        add_load(6'd1, 24'd3);
        add_generate();

        // Randomised phases: no idling with a long receiver hold, then a
        // sparse sender, a stalling receiver, and light idling on both sides.
        run_random_phase(0, 0, 50, 1'b1);
        run_random_phase(72, 0, 50, 1'b0);
        run_random_phase(0, 72, 50, 1'b0);
        run_random_phase(25, 25, 50, 1'b0);

        wait_drained(GEN_LATENCY);
        if (mismatch_cnt == 0 && expected_breaks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a block that stops producing or stops accepting.
    initial begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

endmodule
